// ===== design/ezr_pkg.sv =====
`default_nettype none
package ezr_pkg;

  // Number of CORDIC micro-rotations, limited to the length of the arctangent table.
  localparam int CORDIC_STEPS = 14;
  localparam int AtanEntries  = 24;
  localparam int CordicIters  = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

  // Datapath widths: Q4.30 CORDIC words, Q2.14 sine and cosine, Q4.12 entries.
  localparam int CordW = 34;
  localparam int ScW   = 16;
  localparam int EntW  = 16;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [16:0]      PiQ13      = 17'sd25736;
  localparam logic signed [15:0]      HalfPiQ13  = 16'sd12868;
  localparam logic signed [17:0]      OneQ14     = 18'sd16384;
  localparam logic signed [EntW-1:0]  OneQ12     = 16'sd4096;
  localparam logic [EntW-1:0]         TzReset    = 16'hB000;

  // Row codes of the serialised matrix.
  localparam logic [1:0] RowFirst = 2'd0;
  localparam logic [1:0] RowOne   = 2'd1;
  localparam logic [1:0] RowTwo   = 2'd2;
  localparam logic [1:0] RowLast  = 2'd3;

  // Sine and cosine of one angle, as a lane hands it on.
  typedef struct packed {
    logic                  valid;
    logic signed [ScW-1:0] s;
    logic signed [ScW-1:0] c;
  } ezr_sc_t;

  // Upper three rows of the matrix; column 3 of these rows is always zero.
  typedef struct packed {
    logic                      valid;
    logic [2:0][2:0][EntW-1:0] m;
  } ezr_mat_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] v;
    unique case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/euler_zyx_rotation_matrix.sv =====
`default_nettype none
// Channel   | Signals                                      | Direction
// ----------+----------------------------------------------+----------
// request   | start, busy (out), roll/pitch/yaw_angle_i    | in
// config    | translate_z_we_i, translate_z_i              | in
// result    | result_valid_o, row_index_o, entry_col*_o,   | out
//           | last_row_o                                   |
//
// A request is taken when start is high and busy is low; busy then stays high
// while a down-counter runs out; this spaces requests so that the row
// serialiser, which drives one row a cycle, ends each matrix before the next.
// Each request gives four consecutive row strobes after the three CORDIC
// lanes (CordicIters + 2 stages) and four merge stages.
// Reset clears the pipeline valids, the serialiser and sets translate_z to -5.0.
// The receiver cannot stall; rows are shown for exactly one cycle.
module euler_zyx_rotation_matrix import ezr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] roll_angle_i,
  input  wire logic [15:0] pitch_angle_i,
  input  wire logic [15:0] yaw_angle_i,
  input  wire logic        translate_z_we_i,
  input  wire logic [15:0] translate_z_i,
  output logic             result_valid_o,
  output logic [1:0]       row_index_o,
  output logic [15:0]      entry_col0_o,
  output logic [15:0]      entry_col1_o,
  output logic [15:0]      entry_col2_o,
  output logic [15:0]      entry_col3_o,
  output logic             last_row_o
);

  // Configuration register.
  logic [EntW-1:0] tz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q <= TzReset;
    end else if (translate_z_we_i) begin
      tz_q <= translate_z_i;
    end
  end

  // Request spacing: a down-counter holds off requests after each accept.
  logic [1:0] gap_q, gap_d;
  logic       accept;
  assign busy   = (gap_q != 2'd0);
  assign accept = start & ~busy;
  always_comb begin
    gap_d = gap_q;
    if (accept) begin
      gap_d = 2'd3;
    end else if (busy) begin
      gap_d = gap_q - 2'd1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 2'd0;
    end else begin
      gap_q <= gap_d;
    end
  end

  // One CORDIC lane per angle.
  ezr_sc_t roll_sc, pitch_sc, yaw_sc;
  ezr_cordic_lane u_roll (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(roll_angle_i), .sc_o(roll_sc)
  );
  ezr_cordic_lane u_pitch (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(pitch_angle_i), .sc_o(pitch_sc)
  );
  ezr_cordic_lane u_yaw (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(yaw_angle_i), .sc_o(yaw_sc)
  );

  // Merge the lanes into the matrix.
  ezr_mat_t mat;
  ezr_matrix_merge u_merge (
    .clk_i, .rst_ni, .roll_i(roll_sc), .pitch_i(pitch_sc), .yaw_i(yaw_sc), .mat_o(mat)
  );

  // Row serialiser: hold the matrix and step through its rows.
  logic [2:0][2:0][EntW-1:0] hold_q;
  logic                      out_vld_q, out_vld_d;
  logic [1:0]                row_q, row_d;

  always_ff @(posedge clk_i) begin
    if (mat.valid) begin
      hold_q <= mat.m;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    row_d     = row_q;
    if (mat.valid) begin
      out_vld_d = 1'b1;
      row_d     = RowFirst;
    end else if (out_vld_q) begin
      if (row_q == RowLast) begin
        out_vld_d = 1'b0;
      end else begin
        row_d = row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      row_q     <= RowFirst;
    end else begin
      out_vld_q <= out_vld_d;
      row_q     <= row_d;
    end
  end

  // Row selection; the bottom row is fixed apart from the translation.
  always_comb begin
    unique case (row_q)
      RowFirst, RowOne, RowTwo: begin
        entry_col0_o = hold_q[row_q][0];
        entry_col1_o = hold_q[row_q][1];
        entry_col2_o = hold_q[row_q][2];
        entry_col3_o = '0;
      end
      RowLast: begin
        entry_col0_o = '0;
        entry_col1_o = '0;
        entry_col2_o = tz_q;
        entry_col3_o = OneQ12;
      end
      default: begin
        entry_col0_o = '0;
        entry_col1_o = '0;
        entry_col2_o = '0;
        entry_col3_o = '0;
      end
    endcase
  end

  assign result_valid_o = out_vld_q;
  assign row_index_o    = row_q;
  assign last_row_o     = out_vld_q & (row_q == RowLast);

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("busy not raised after an accepted request");
  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && row_index_o != RowLast |=> result_valid_o &&
    row_index_o == $past(row_index_o) + 2'd1) else $error("matrix rows broken up");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_row_o |-> result_valid_o && row_index_o == RowLast)
    else $error("last row flag on a wrong row");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mat.valid && out_vld_q |-> row_q == RowLast)
    else $error("new matrix overran the serialiser");
`endif

endmodule
`default_nettype wire

// ===== design/ezr_cordic_lane.sv =====
`default_nettype none
module ezr_cordic_lane import ezr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] angle_i,
  output ezr_sc_t                 sc_o
);

  logic signed [CordW-1:0] x_q [0:CordicIters];
  logic signed [CordW-1:0] y_q [0:CordicIters];
  logic signed [CordW-1:0] z_q [0:CordicIters];
  logic                    neg_q [0:CordicIters];
  logic                    vld_q [0:CordicIters];

  // Fold the angle into the CORDIC's reach of plus or minus pi/2.
  logic signed [16:0] a_fold;
  logic               neg_fold;
  always_comb begin
    a_fold   = 17'(angle_i);
    neg_fold = 1'b0;
    if (angle_i > HalfPiQ13) begin
      a_fold   = 17'(angle_i) - PiQ13;
      neg_fold = 1'b1;
    end else if (angle_i < -HalfPiQ13) begin
      a_fold   = 17'(angle_i) + PiQ13;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= CordicGain;
    y_q[0]   <= '0;
    z_q[0]   <= CordW'(a_fold) <<< 17;
    neg_q[0] <= neg_fold;
  end

  // One micro-rotation per pipeline stage.
  for (genvar i = 0; i < CordicIters; i++) begin : g_step
    localparam logic [4:0] Idx = 5'(i);
    logic signed [CordW-1:0] atan_w;
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    assign atan_w = {3'b000, atan_q30(Idx)};
    assign dx     = y_q[i] >>> i;
    assign dy     = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[i+1] <= neg_q[i];
      if (!z_q[i][CordW-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - atan_w;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + atan_w;
      end
    end
  end

  // Round to Q2.14, clamp to the unit range and undo the fold.
  logic signed [CordW-1:0] x_rnd;
  logic signed [CordW-1:0] y_rnd;
  logic signed [17:0]      x_sh;
  logic signed [17:0]      y_sh;
  logic signed [17:0]      x_cl;
  logic signed [17:0]      y_cl;
  always_comb begin
    x_rnd = (x_q[CordicIters] + 34'sd32768) >>> 16;
    y_rnd = (y_q[CordicIters] + 34'sd32768) >>> 16;
    x_sh  = x_rnd[17:0];
    y_sh  = y_rnd[17:0];
    x_cl  = (x_sh > OneQ14) ? OneQ14 : ((x_sh < -OneQ14) ? -OneQ14 : x_sh);
    y_cl  = (y_sh > OneQ14) ? OneQ14 : ((y_sh < -OneQ14) ? -OneQ14 : y_sh);
    if (neg_q[CordicIters]) begin
      x_cl = -x_cl;
      y_cl = -y_cl;
    end
  end

  logic                  sc_vld_q;
  logic signed [ScW-1:0] s_q;
  logic signed [ScW-1:0] c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else begin
      sc_vld_q <= vld_q[CordicIters];
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= y_cl[ScW-1:0];
    c_q <= x_cl[ScW-1:0];
  end

  assign sc_o = {sc_vld_q, s_q, c_q};

endmodule
`default_nettype wire

// ===== design/ezr_matrix_merge.sv =====
`default_nettype none
module ezr_matrix_merge import ezr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire ezr_sc_t roll_i,
  input  wire ezr_sc_t pitch_i,
  input  wire ezr_sc_t yaw_i,
  output ezr_mat_t     mat_o
);

  // Stage A: the four products of Ry * Rx that need rounding.
  logic signed [31:0]    spsr_q, spcr_q, cpsr_q, cpcr_q;
  logic signed [ScW-1:0] a_sp_q, a_cp_q, a_sr_q, a_cr_q, a_sy_q, a_cy_q;
  logic                  a_vld_q;

  always_ff @(posedge clk_i) begin
    spsr_q <= pitch_i.s * roll_i.s;
    spcr_q <= pitch_i.s * roll_i.c;
    cpsr_q <= pitch_i.c * roll_i.s;
    cpcr_q <= pitch_i.c * roll_i.c;
    a_sp_q <= pitch_i.s;
    a_cp_q <= pitch_i.c;
    a_sr_q <= roll_i.s;
    a_cr_q <= roll_i.c;
    a_sy_q <= yaw_i.s;
    a_cy_q <= yaw_i.c;
  end

  // Stage B: round the product matrix P to Q2.14.
  logic signed [31:0]    r01, r02, r21, r22;
  logic signed [ScW-1:0] p00_q, p01_q, p02_q, p11_q, p12_q, p20_q, p21_q, p22_q;
  logic signed [ScW-1:0] b_sy_q, b_cy_q;
  logic                  b_vld_q;

  assign r01 = (spsr_q + 32'sd8192) >>> 14;
  assign r02 = (spcr_q + 32'sd8192) >>> 14;
  assign r21 = (cpsr_q + 32'sd8192) >>> 14;
  assign r22 = (cpcr_q + 32'sd8192) >>> 14;

  always_ff @(posedge clk_i) begin
    p00_q  <= a_cp_q;
    p01_q  <= r01[ScW-1:0];
    p02_q  <= r02[ScW-1:0];
    p11_q  <= a_cr_q;
    p12_q  <= -a_sr_q;
    p20_q  <= -a_sp_q;
    p21_q  <= r21[ScW-1:0];
    p22_q  <= r22[ScW-1:0];
    b_sy_q <= a_sy_q;
    b_cy_q <= a_cy_q;
  end

  // Stage C: products of Rz with the upper two rows of P.
  logic signed [31:0]    cy0_q, cy1_q, cy2_q, sy0_q, sy1_q, sy2_q;
  logic signed [31:0]    sy11_q, sy12_q, cy11_q, cy12_q;
  logic signed [ScW-1:0] c_p20_q, c_p21_q, c_p22_q;
  logic                  c_vld_q;

  always_ff @(posedge clk_i) begin
    cy0_q   <= b_cy_q * p00_q;
    cy1_q   <= b_cy_q * p01_q;
    cy2_q   <= b_cy_q * p02_q;
    sy0_q   <= b_sy_q * p00_q;
    sy1_q   <= b_sy_q * p01_q;
    sy2_q   <= b_sy_q * p02_q;
    sy11_q  <= b_sy_q * p11_q;
    sy12_q  <= b_sy_q * p12_q;
    cy11_q  <= b_cy_q * p11_q;
    cy12_q  <= b_cy_q * p12_q;
    c_p20_q <= p20_q;
    c_p21_q <= p21_q;
    c_p22_q <= p22_q;
  end

  // Stage D: sum and round to Q4.12.
  function automatic logic [EntW-1:0] rnd16(input logic signed [32:0] s);
    logic signed [32:0] t;
    t = (s + 33'sd32768) >>> 16;
    return t[EntW-1:0];
  endfunction

  function automatic logic [EntW-1:0] rnd2(input logic signed [ScW-1:0] p);
    logic signed [17:0] t;
    t = (18'(p) + 18'sd2) >>> 2;
    return t[EntW-1:0];
  endfunction

  logic [2:0][2:0][EntW-1:0] m_q;
  logic                      d_vld_q;
  always_ff @(posedge clk_i) begin
    m_q[0][0] <= rnd16(33'(cy0_q));
    m_q[0][1] <= rnd16(33'(cy1_q) - 33'(sy11_q));
    m_q[0][2] <= rnd16(33'(cy2_q) - 33'(sy12_q));
    m_q[1][0] <= rnd16(33'(sy0_q));
    m_q[1][1] <= rnd16(33'(sy1_q) + 33'(cy11_q));
    m_q[1][2] <= rnd16(33'(sy2_q) + 33'(cy12_q));
    m_q[2][0] <= rnd2(c_p20_q);
    m_q[2][1] <= rnd2(c_p21_q);
    m_q[2][2] <= rnd2(c_p22_q);
  end

  // Valid travels alongside the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= roll_i.valid & pitch_i.valid & yaw_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  assign mat_o = {d_vld_q, m_q};

endmodule
`default_nettype wire

// ===== tb/tb_euler_zyx_rotation_matrix.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_euler_zyx_rotation_matrix;
  import ezr_pkg::*;

  typedef struct packed {
    logic [1:0]  row;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic        last;
  } row_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] roll_angle_i = '0;
  logic [15:0] pitch_angle_i = '0;
  logic [15:0] yaw_angle_i = '0;
  logic        translate_z_we_i = 1'b0;
  logic [15:0] translate_z_i = '0;
  logic        result_valid_o;
  logic [1:0]  row_index_o;
  logic [15:0] entry_col0_o;
  logic [15:0] entry_col1_o;
  logic [15:0] entry_col2_o;
  logic [15:0] entry_col3_o;
  logic        last_row_o;

  row_t        expected_rows[$];
  logic [15:0] tz_model;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned request_count = 0;
  int unsigned row_count = 0;
  int unsigned send_idle_pct = 0;

  euler_zyx_rotation_matrix dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .roll_angle_i(roll_angle_i),
    .pitch_angle_i(pitch_angle_i),
    .yaw_angle_i(yaw_angle_i),
    .translate_z_we_i(translate_z_we_i),
    .translate_z_i(translate_z_i),
    .result_valid_o(result_valid_o),
    .row_index_o(row_index_o),
    .entry_col0_o(entry_col0_o),
    .entry_col1_o(entry_col1_o),
    .entry_col2_o(entry_col2_o),
    .entry_col3_o(entry_col3_o),
    .last_row_o(last_row_o)
  );

  always #2 clk_i = ~clk_i;

  // Rounding shift right: adds half an LSB, then shifts arithmetically.
  function automatic longint rnd_shift(input longint v, input int sh);
    longint t;
    t = v + (64'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

  function automatic longint clamp_one(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // Sine and cosine of a Q3.13 angle as Q2.14, by folding and CORDIC.
  task automatic angle_sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a = longint'($signed(ang));
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a > 12868) begin
      a -= 25736;
      flip = 1'b1;
    end else if (a < -12868) begin
      a += 25736;
      flip = 1'b1;
    end
    z = a * 131072;
    for (int i = 0; i < CordicIters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_q30(5'(i)));
      end
    end
    x = clamp_one(rnd_shift(x, 16));
    y = clamp_one(rnd_shift(y, 16));
    if (flip) begin
      x = -x;
      y = -y;
    end
    sn = y;
    cs = x;
  endtask

  // Builds the four expected rows of Rz * (Ry * Rx) for one request.
  task automatic predict_pose(input logic [15:0] roll, input logic [15:0] pitch,
                              input logic [15:0] yaw);
    longint sr, cr, sp, cp, sy, cy, acc;
    longint rx[4][4], ry[4][4], rz[4][4], p[4][4], m[4][4];
    row_t   r;
    angle_sin_cos(roll, sr, cr);
    angle_sin_cos(pitch, sp, cp);
    angle_sin_cos(yaw, sy, cy);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        rx[i][j] = (i == j) ? 16384 : 0;
        ry[i][j] = rx[i][j];
        rz[i][j] = rx[i][j];
      end
    rx[1][1] = cr; rx[1][2] = -sr; rx[2][1] = sr; rx[2][2] = cr;
    ry[0][0] = cp; ry[0][2] = sp; ry[2][0] = -sp; ry[2][2] = cp;
    rz[0][0] = cy; rz[0][1] = -sy; rz[1][0] = sy; rz[1][1] = cy;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += ry[i][k] * rx[k][j];
        p[i][j] = rnd_shift(acc, 14);
      end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += rz[i][k] * p[k][j];
        m[i][j] = rnd_shift(acc, 16);
      end
    for (int i = 0; i < 4; i++) begin
      r.row  = 2'(i);
      r.c0   = 16'(m[i][0]);
      r.c1   = 16'(m[i][1]);
      r.c2   = (i == 3) ? tz_model : 16'(m[i][2]);
      r.c3   = 16'(m[i][3]);
      r.last = (i == 3);
      expected_rows.push_back(r);
    end
  endtask

  // Sends one request, with a random gap before it. Start stays high after
  // the accepting edge until the next request or an idle cycle replaces it.
  task automatic send_pose(input logic [15:0] roll, input logic [15:0] pitch,
                           input logic [15:0] yaw);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    roll_angle_i <= roll;
    pitch_angle_i <= pitch;
    yaw_angle_i <= yaw;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_pose(roll, pitch, yaw);
    request_count++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tz(input logic [15:0] v);
    wait_idle();
    translate_z_we_i <= 1'b1;
    translate_z_i <= v;
    @(posedge clk_i);
    translate_z_we_i <= 1'b0;
    tz_model = v;
  endtask

  function automatic logic [15:0] rand_angle();
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  // Zero, the quadrant edges, pi and full-range bit patterns.
  task automatic test_directed();
    logic [15:0] pts[12];
    pts = '{16'd0, 16'd12868, 16'd12869, -16'sd12868, -16'sd12869, 16'd25736,
            -16'sd25736, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd1, 16'd6434};
    foreach (pts[i]) send_pose(pts[i], pts[(i + 4) % 12], pts[(i + 8) % 12]);
    send_pose(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pose(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_translate_extremes();
    write_tz(16'h7FFF);
    send_pose(16'd1000, -16'sd2000, 16'd3000);
    write_tz(16'h8000);
    send_pose(16'd25736, 16'd0, -16'sd12868);
    write_tz(16'h0000);
    send_pose(16'd0, 16'd6434, 16'd0);
  endtask

  // Random poses, mostly in range with a few arbitrary bit patterns.
  task automatic test_random(input int n, input int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_pose(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_pose(rand_angle(), rand_angle(), rand_angle());
    end
  endtask

  // Compares each row strobe with the oldest expected row.
  always @(posedge clk_i) begin
    row_t e;
    if (rst_ni && result_valid_o) begin
      row_count++;
      if (expected_rows.size() == 0) begin
        $error("Unexpected row %0d", row_index_o);
        err_count++;
      end else begin
        e = expected_rows.pop_front();
        if (row_index_o !== e.row) begin
          $error("row_index expected %0d got %0d", e.row, row_index_o); err_count++;
        end
        if (entry_col0_o !== e.c0) begin
          $error("entry_col0 expected %h got %h", e.c0, entry_col0_o); err_count++;
        end
        if (entry_col1_o !== e.c1) begin
          $error("entry_col1 expected %h got %h", e.c1, entry_col1_o); err_count++;
        end
        if (entry_col2_o !== e.c2) begin
          $error("entry_col2 expected %h got %h", e.c2, entry_col2_o); err_count++;
        end
        if (entry_col3_o !== e.c3) begin
          $error("entry_col3 expected %h got %h", e.c3, entry_col3_o); err_count++;
        end
        if (last_row_o !== e.last) begin
          $error("last_row expected %0d got %0d", e.last, last_row_o); err_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    tz_model = TzReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_translate_extremes();
    write_tz(16'(-16'sd20480));
    test_random(50, 12);
    write_tz(16'($urandom));
    test_random(50, 51);
    write_tz(16'h1000);
    test_random(50, 0);
    wait_idle();
    $display("Covered %0d poses and %0d rows, including quadrant edges,",
             request_count, row_count);
    $display("out-of-range angles and extreme z translations.");
    if (err_count == 0 && expected_rows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/ezr_pkg.sv
design/ezr_cordic_lane.sv
design/ezr_matrix_merge.sv
design/euler_zyx_rotation_matrix.sv
tb/tb_euler_zyx_rotation_matrix.sv
